// ===== sv/mmr_pkg.sv =====
// shared types and codes of the message mailbox ring
package mmr_pkg;

   localparam int LEN_W = 6;

   typedef enum logic {
      FUNC_PLACE = 1'b0,
      FUNC_PICK  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      KIND_PLACE = 2'd0,
      KIND_HDR   = 2'd1,
      KIND_DATA  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_RETRY  = 2'd1,
      STAT_TOOBIG = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ZERO = 4'b0010,
      ST_HDR  = 4'b0100,
      ST_DATA = 4'b1000
   } state_type;

   typedef struct packed {
      logic        func;
      logic [31:0] event_req;
      logic [31:0] source;
      logic [15:0] length;
      logic [7:0]  data_byte;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [1:0]       status;
      logic [31:0]      event_out;
      logic [31:0]      source_out;
      logic [LEN_W-1:0] length_out;
      logic [7:0]       data_out;
      logic             last_out;
      logic             wake_reader;
      logic             block_reader;
   } rsp_type;

   typedef struct packed {
      logic [31:0]      event_code;
      logic [31:0]      source;
      logic [LEN_W-1:0] length;
   } slot_hdr_type;

endpackage

// ===== sv/message_mailbox_ring_core.sv =====
// message mailbox ring: top level with slot pointers, place runs and pick streaming
//
// The mailbox keeps SLOT_COUNT message slots as a ring with free-running head
// and tail pointers. Slot headers (event, source, length) live in a header ram
// of SLOT_COUNT entries and payload bytes in a payload ram of
// SLOT_COUNT*SLOT_BYTES bytes; both rams start undefined and get no clearing
// pass, so the block takes items right after reset. A place run takes one
// byte item per cycle while the result output is free; its last item answers
// in the next cycle, except when an accepted run delivered fewer bytes than
// its length: the missing bytes are then written as zero through the payload
// write port, one per cycle, before the status comes out. A pick on an empty
// ring answers with a retry header and no ram read. Otherwise the header ram
// is read first, then the header and the payload bytes stream out at one item
// per cycle, paced by the payload read port and by rsp_ready. One item is
// worked on at a time; req_ready is low while a pick streams or a zero fill runs.
module message_mailbox_ring_core
   import mmr_pkg::*;
#(
   parameter int SLOT_COUNT = 16,
   parameter int SLOT_BYTES = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int PW            = $clog2(2 * SLOT_COUNT);
   localparam int HW            = PW + 1;
   localparam int SW            = $clog2(SLOT_COUNT);
   localparam int PTR_LAST      = 2 * SLOT_COUNT - 1;
   localparam int PAYLOAD_DEPTH = SLOT_COUNT * SLOT_BYTES;
   localparam int PAW           = $clog2(PAYLOAD_DEPTH);
   localparam int HDR_W         = $bits(slot_hdr_type);

   function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] p);
      logic [SW-1:0] s;
      if (p >= PW'(SLOT_COUNT)) begin
         s = SW'(p - PW'(SLOT_COUNT));
      end else begin
         s = SW'(p);
      end
      return s;
   endfunction

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      logic [PW-1:0] n;
      if (p == PW'(PTR_LAST)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   function automatic logic [PAW-1:0] addr_of(input logic [SW-1:0] s,
                                              input logic [LEN_W-1:0] idx);
      return PAW'(s) * PAW'(SLOT_BYTES) + PAW'(idx);
   endfunction

   state_type        state_ff, state_in;
   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic             run_active_ff, run_active_in;
   logic [1:0]       run_status_ff, run_status_in;
   logic [LEN_W-1:0] run_len_ff, run_len_in;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [15:0]      cap_ff, cap_in;
   logic [SW-1:0]    pslot_ff, pslot_in;
   logic [LEN_W-1:0] slen_ff, slen_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             out_free;
   logic             req_fire;
   logic [HW-1:0]    held;
   logic             ring_empty;
   logic             ring_full;
   logic [SW-1:0]    hs;
   logic [SW-1:0]    ts;

   // place decode
   logic             first;
   logic [1:0]       status_new;
   logic [LEN_W-1:0] len_new;
   logic [LEN_W-1:0] fill_base;
   logic             wr_byte;
   logic [LEN_W-1:0] fill_new;
   logic [LEN_W-1:0] fill_inc;
   logic [LEN_W-1:0] slen_rd;
   logic [LEN_W-1:0] idx_inc;

   // ram ports
   logic             hdr_we, hdr_re;
   slot_hdr_type     hdr_wdata;
   logic [HDR_W-1:0] hdr_rbits;
   slot_hdr_type     hdr_rdata;
   logic             pay_we, pay_re;
   logic [PAW-1:0]   pay_waddr, pay_raddr;
   logic [7:0]       pay_wdata, pay_rdata;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_valid && req_ready;
   assign held       = (head_ff >= tail_ff)
                     ? ({1'b0, head_ff} - {1'b0, tail_ff})
                     : ({1'b0, head_ff} + HW'(2 * SLOT_COUNT) - {1'b0, tail_ff});
   assign ring_empty = (head_ff == tail_ff);
   assign ring_full  = (held == HW'(SLOT_COUNT));
   assign hs         = slot_of(head_ff);
   assign ts         = slot_of(tail_ff);
   assign hdr_rdata  = slot_hdr_type'(hdr_rbits);
   assign fill_inc   = fill_ff + 1'b1;
   assign idx_inc    = idx_ff + 1'b1;
   assign slen_rd    = (hdr_rdata.length > LEN_W'(SLOT_BYTES))
                     ? LEN_W'(SLOT_BYTES) : hdr_rdata.length;

   always_comb begin
      first = !run_active_ff;
      if (first) begin
         if (ring_full) begin
            status_new = STAT_RETRY;
         end else if (req_data.length > 16'(SLOT_BYTES)) begin
            status_new = STAT_TOOBIG;
         end else begin
            status_new = STAT_OK;
         end
         len_new   = req_data.length[LEN_W-1:0];
         fill_base = '0;
      end else begin
         status_new = run_status_ff;
         len_new    = run_len_ff;
         fill_base  = fill_ff;
      end
      wr_byte  = (status_new == STAT_OK) && (fill_base < len_new);
      fill_new = fill_base + LEN_W'(wr_byte);
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      run_active_in = run_active_ff;
      run_status_in = run_status_ff;
      run_len_in    = run_len_ff;
      fill_in       = fill_ff;
      cap_in        = cap_ff;
      pslot_in      = pslot_ff;
      slen_in       = slen_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;

      hdr_we               = 1'b0;
      hdr_wdata.event_code = req_data.event_req;
      hdr_wdata.source     = req_data.source;
      hdr_wdata.length     = req_data.length[LEN_W-1:0];
      hdr_re               = 1'b0;
      pay_we               = 1'b0;
      pay_waddr            = addr_of(hs, fill_base);
      pay_wdata            = req_data.data_byte;
      pay_re               = 1'b0;
      pay_raddr            = addr_of(ts, '0);

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.func == FUNC_PLACE) begin
               hdr_we = first && (status_new == STAT_OK);
               pay_we = wr_byte;
               run_status_in = status_new;
               run_len_in    = len_new;
               if (!req_data.last) begin
                  run_active_in = 1'b1;
                  fill_in       = fill_new;
               end else if (status_new == STAT_OK && fill_new < len_new) begin
                  // short run: pad the slot with zeros up to the run length first
                  run_active_in = 1'b1;
                  fill_in       = fill_new;
                  state_in      = ST_ZERO;
               end else begin
                  if (status_new == STAT_OK) begin
                     head_in = ptr_next(head_ff);
                  end
                  run_active_in = 1'b0;
                  fill_in       = '0;
                  rsp_valid_in  = 1'b1;
                  rsp_in        = '0;
                  rsp_in.kind        = KIND_PLACE;
                  rsp_in.status      = status_new;
                  rsp_in.last_out    = 1'b1;
                  rsp_in.wake_reader = (status_new == STAT_OK);
               end
            end else if (req_fire) begin
               if (ring_empty) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in              = '0;
                  rsp_in.kind         = KIND_HDR;
                  rsp_in.status       = STAT_RETRY;
                  rsp_in.last_out     = 1'b1;
                  rsp_in.block_reader = 1'b1;
               end else begin
                  hdr_re   = 1'b1;
                  pay_re   = 1'b1;
                  cap_in   = req_data.length;
                  pslot_in = ts;
                  state_in = ST_HDR;
               end
            end
         end
         ST_ZERO: begin
            pay_we    = 1'b1;
            pay_waddr = addr_of(hs, fill_ff);
            pay_wdata = '0;
            fill_in   = fill_inc;
            if (fill_inc == run_len_ff) begin
               head_in            = ptr_next(head_ff);
               run_active_in      = 1'b0;
               fill_in            = '0;
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.kind        = KIND_PLACE;
               rsp_in.status      = STAT_OK;
               rsp_in.last_out    = 1'b1;
               rsp_in.wake_reader = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_HDR: begin
            if (out_free) begin
               tail_in           = ptr_next(tail_ff);
               rsp_valid_in      = 1'b1;
               rsp_in            = '0;
               rsp_in.kind       = KIND_HDR;
               rsp_in.event_out  = hdr_rdata.event_code;
               rsp_in.source_out = hdr_rdata.source;
               rsp_in.length_out = slen_rd;
               if (16'(slen_rd) > cap_ff) begin
                  // consumed but dropped
                  rsp_in.status   = STAT_TOOBIG;
                  rsp_in.last_out = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  rsp_in.status   = STAT_OK;
                  rsp_in.last_out = (slen_rd == '0);
                  slen_in         = slen_rd;
                  idx_in          = '0;
                  state_in        = (slen_rd == '0) ? ST_IDLE : ST_DATA;
               end
            end
         end
         ST_DATA: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in          = '0;
               rsp_in.kind     = KIND_DATA;
               rsp_in.status   = STAT_OK;
               rsp_in.data_out = pay_rdata;
               rsp_in.last_out = (idx_inc == slen_ff);
               if (idx_inc == slen_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  // fetch the next byte while this one goes out
                  pay_re    = 1'b1;
                  pay_raddr = addr_of(pslot_ff, idx_inc);
                  idx_in    = idx_inc;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         run_active_ff <= 1'b0;
         run_status_ff <= STAT_OK;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         run_active_ff <= run_active_in;
         run_status_ff <= run_status_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_len_ff <= run_len_in;
      cap_ff     <= cap_in;
      pslot_ff   <= pslot_in;
      slen_ff    <= slen_in;
      idx_ff     <= idx_in;
      rsp_ff     <= rsp_in;
   end

   mmr_ram #(
      .WIDTH (HDR_W),
      .DEPTH (SLOT_COUNT)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (hdr_we),
      .wr_addr (hs),
      .wr_data (hdr_wdata),
      .rd_en   (hdr_re),
      .rd_addr (ts),
      .rd_data (hdr_rbits)
   );

   mmr_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_DEPTH)
   ) u_pay_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (pay_waddr),
      .wr_data (pay_wdata),
      .rd_en   (pay_re),
      .rd_addr (pay_raddr),
      .rd_data (pay_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/mmr_ram.sv =====
// generic single write port, single read port ram with registered read
module mmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mmr_checker.sv =====
// port-level checks of the message mailbox ring, bound to its top level
module mmr_checker
   import mmr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result keeps its valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled result keeps its item
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // wake only on a successful place status
   a_wake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.wake_reader ==
         (rsp_data.kind == KIND_PLACE && rsp_data.status == STAT_OK)))
      else $error("wake_reader does not match place status");

   // an empty pick is a lone retry header with no message fields
   a_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.block_reader |->
         rsp_data.kind == KIND_HDR && rsp_data.status == STAT_RETRY &&
         rsp_data.last_out && rsp_data.event_out == '0 &&
         rsp_data.source_out == '0 && rsp_data.length_out == '0)
      else $error("malformed empty pick result");

   // a header with more to follow is followed by payload bytes
   a_hdr_then_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.kind == KIND_HDR && !rsp_data.last_out
      |=> (!rsp_valid || rsp_data.kind == KIND_DATA))
      else $error("payload stream broken after header");

endmodule

bind message_mailbox_ring_core mmr_checker u_mmr_checker (.*);
